// ===== hdl/sps_pkg.sv =====
`timescale 1ns / 1ps

package sps_pkg;

  // Number of (key, payload) pairs one batch can hold.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  // One stored pair; the key sits in the low half.
  typedef struct packed {
    logic signed [WORD_W-1:0] payload;
    logic signed [WORD_W-1:0] key;
  } pair_t;

  // Write request into the pair store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    pair_t            data;
  } store_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_FETCH,
    S_SHOW
  } state_t;

endpackage

// ===== hdl/sps_store.sv =====
`timescale 1ns / 1ps

module sps_store (
  input  logic                      clk,
  input  sps_pkg::store_wr_t        wr,
  input  logic                      rd_en,
  input  logic [sps_pkg::IDX_W-1:0] rd_addr,
  output sps_pkg::pair_t            rd_data
);

  sps_pkg::pair_t mem [sps_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/stable_pair_insertion_sorter_unit.sv =====
`timescale 1ns / 1ps

// Stable insertion sorter. Each input item carries one (key, payload) pair, and the
// pairs of a batch are kept in a 32-entry store in ascending signed key order; a new
// pair lands after every stored pair with an equal key. One comparator walks the store
// downward from the top entry, moving one larger entry up per cycle, and s_tready stays
// low meanwhile. The item marked by s_tlast starts the readout: every stored pair
// leaves in order, each one read from the store in S_FETCH and then held in S_SHOW
// until m_tready takes it, with m_tlast on the last one. Pairs that arrive while the
// store is full are dropped, and m_tuser is then high on every result of that batch.
// After the readout the batch is cleared and the next item is taken.

module stable_pair_insertion_sorter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] key, [63:32] payload
  input  logic        s_tlast,   // batch_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] sorted_key, [63:32] sorted_payload
  output logic        m_tlast,   // final_result
  output logic        m_tuser    // overflow
);

  localparam int IDX_W = sps_pkg::IDX_W;
  localparam int CNT_W = sps_pkg::CNT_W;

  sps_pkg::state_t state, state_next;

  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] out_idx, out_idx_next;
  logic             dropped, dropped_next;
  logic             batch_last, batch_last_next;
  sps_pkg::pair_t   new_pair, new_pair_next;

  sps_pkg::store_wr_t wr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  sps_pkg::pair_t     rd_data;

  logic             store_full;
  logic             key_greater;
  logic [CNT_W-1:0] pos_dec;
  logic             out_is_last;

  sps_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign store_full  = (fill_count == CNT_W'(sps_pkg::CAPACITY));
  // The shared comparator: stored key against the key being inserted.
  assign key_greater = (rd_data.key > new_pair.key);
  assign pos_dec     = pos - CNT_W'(1);
  assign out_is_last = ((out_idx + CNT_W'(1)) == fill_count);

  assign s_tready = (state == sps_pkg::S_IDLE);
  assign m_tvalid = (state == sps_pkg::S_SHOW);
  assign m_tdata  = rd_data;
  assign m_tlast  = out_is_last;
  assign m_tuser  = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sps_pkg::S_IDLE;
      fill_count <= '0;
      dropped    <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      dropped    <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    out_idx    <= out_idx_next;
    batch_last <= batch_last_next;
    new_pair   <= new_pair_next;
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    dropped_next    = dropped;
    pos_next        = pos;
    out_idx_next    = out_idx;
    batch_last_next = batch_last;
    new_pair_next   = new_pair;
    wr.en           = 1'b0;
    wr.addr         = pos[IDX_W-1:0];
    wr.data         = new_pair;
    rd_en           = 1'b0;
    rd_addr         = pos_dec[IDX_W-1:0];

    case (state)
      sps_pkg::S_IDLE: begin
        if (s_tvalid) begin
          new_pair_next   = s_tdata;
          batch_last_next = s_tlast;
          pos_next        = fill_count;
          out_idx_next    = '0;
          if (store_full) begin
            dropped_next = 1'b1;
            state_next   = s_tlast ? sps_pkg::S_FETCH : sps_pkg::S_IDLE;
          end else if (fill_count == '0) begin
            state_next = sps_pkg::S_PLACE;
          end else begin
            // Fetch the top entry for the first compare.
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(fill_count - CNT_W'(1));
            state_next = sps_pkg::S_SHIFT;
          end
        end
      end

      sps_pkg::S_SHIFT: begin
        wr.en = 1'b1;
        if (key_greater) begin
          // Move the larger entry up one place and look one entry lower.
          wr.data  = rd_data;
          pos_next = pos_dec;
          if (pos_dec == '0) begin
            state_next = sps_pkg::S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(pos_dec - CNT_W'(1));
          end
        end else begin
          fill_count_next = fill_count + CNT_W'(1);
          state_next      = batch_last ? sps_pkg::S_FETCH : sps_pkg::S_IDLE;
        end
      end

      sps_pkg::S_PLACE: begin
        wr.en           = 1'b1;
        fill_count_next = fill_count + CNT_W'(1);
        state_next      = batch_last ? sps_pkg::S_FETCH : sps_pkg::S_IDLE;
      end

      sps_pkg::S_FETCH: begin
        rd_en      = 1'b1;
        rd_addr    = out_idx[IDX_W-1:0];
        state_next = sps_pkg::S_SHOW;
      end

      sps_pkg::S_SHOW: begin
        if (m_tready) begin
          if (out_is_last) begin
            fill_count_next = '0;
            dropped_next    = 1'b0;
            state_next      = sps_pkg::S_IDLE;
          end else begin
            out_idx_next = out_idx + CNT_W'(1);
            state_next   = sps_pkg::S_FETCH;
          end
        end
      end

      default: begin
        state_next = sps_pkg::S_IDLE;
      end
    endcase
  end

  // The fill count never passes the store size.
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(sps_pkg::CAPACITY))
    else $error("fill count exceeds capacity");

  // A result is only shown while the store holds pairs.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fill_count != '0) && (out_idx < fill_count))
    else $error("result shown from an empty or exhausted store");

  // The downward walk never runs below entry zero.
  assert property (@(posedge clk) disable iff (rst)
    (state == sps_pkg::S_SHIFT) |-> (pos != '0))
    else $error("insertion walk below entry zero");

  // A completed readout leaves the batch cleared.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (fill_count == '0) && !dropped)
    else $error("batch not cleared after readout");

endmodule

// ===== dv/tb_stable_pair_insertion_sorter_unit.sv =====
`timescale 1ns / 1ps

module tb_stable_pair_insertion_sorter_unit;

  localparam int CYCLE_LIMIT = 200000;

  // One sorted pair as it should leave the block.
  typedef struct packed {
    sps_pkg::pair_t pair;
    logic           last;
    logic           ovf;
  } sorted_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  stable_pair_insertion_sorter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Shadow copy of the batch store and the queue of pairs still to come out.
  sps_pkg::pair_t batch_pairs [sps_pkg::CAPACITY];
  int unsigned    batch_fill;
  bit             batch_dropped;
  sorted_item_t   sorted_q[$];

  int             idle_pct = 30;  // chance in percent that an idle burst starts
  int             sink_stall;
  int             fail_count;
  int             pairs_sent;
  int unsigned    cycle_count;

  // Stable insertion: the new pair goes above every stored pair with an equal key.
  // A pair that finds the store full is dropped and marks the batch.
  function automatic void insert_and_predict(sps_pkg::pair_t in_pair, logic last);
    int           pos;
    sorted_item_t item;
    if (batch_fill < sps_pkg::CAPACITY) begin
      pos = batch_fill;
      while (pos > 0 && $signed(batch_pairs[pos-1].key) > $signed(in_pair.key)) begin
        batch_pairs[pos] = batch_pairs[pos-1];
        pos--;
      end
      batch_pairs[pos] = in_pair;
      batch_fill++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < batch_fill; i++) begin
        item.pair = batch_pairs[i];
        item.last = (i == batch_fill - 1);
        item.ovf  = batch_dropped;
        sorted_q  = {sorted_q, item};
      end
      batch_fill    = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // Keys lean on ties and on the ends of the signed range.
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh7ffffffe;
          default: return 32'sh80000001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Drives one item at the falling edge and returns at the edge where it is taken.
  // While the bus is idle the data lines carry junk that the block must ignore.
  task automatic send_pair(input logic signed [31:0] k, input logic signed [31:0] p,
                           input logic last);
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      s_tlast  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, k};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    insert_and_predict('{payload: p, key: k}, last);
    pairs_sent++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
  endtask

  // A batch of random pairs; only the final one carries the batch end.
  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++)
      send_pair(pick_key(), $urandom, i == len - 1);
  endtask

  // One-pair batches at the corners of both fields.
  task automatic test_single_pair_batches();
    send_pair(32'sh80000000, 32'sh7fffffff, 1'b1);
    send_pair(32'sh7fffffff, 32'sh80000000, 1'b1);
    send_pair(32'sh00000000, 32'shffffffff, 1'b1);
    release_bus();
  endtask

  // Mixed extremes with repeated keys, where ties must keep arrival order.
  task automatic test_extremes_and_ties();
    send_pair(32'sd7,          32'sd1,  1'b0);
    send_pair(32'sh80000000,   32'sd2,  1'b0);
    send_pair(32'sd7,          32'sd3,  1'b0);
    send_pair(32'sh7fffffff,   32'sd4,  1'b0);
    send_pair(-32'sd1,         32'sd5,  1'b0);
    send_pair(32'sd7,          32'sd6,  1'b0);
    send_pair(32'sd0,          32'sd7,  1'b0);
    send_pair(32'sh80000000,   32'sd8,  1'b0);
    send_pair(32'sd1,          32'sd9,  1'b0);
    send_pair(32'sh7fffffff,   32'sd10, 1'b1);
    // All keys equal: the output order must be the arrival order.
    for (int i = 0; i < 5; i++)
      send_pair(-32'sd5, 32'sh5a5a0000 + i, i == 4);
    // Strictly falling keys make every pair shift the whole store.
    for (int i = 0; i < 5; i++)
      send_pair(32'sd100 - 32'sd40 * i, ~i, i == 4);
    release_bus();
  endtask

  // Exactly full is not an overflow; pairs past that are dropped,
  // including the pair that ends the batch.
  task automatic test_full_store();
    send_batch(sps_pkg::CAPACITY);
    send_batch(sps_pkg::CAPACITY + 2);
    release_bus();
  endtask

  // Mostly short batches, now and then long or overfull ones, with the idle
  // rate changed between batches so that some stretches run without gaps.
  // The stretch stops once 150 items have been sent in all.
  task automatic test_random_batches();
    int target;
    int len;
    target = 150;
    while (pairs_sent < target) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(0, 19))
        0: len = $urandom_range(sps_pkg::CAPACITY + 1, sps_pkg::CAPACITY + 8);
        1, 2, 3: len = $urandom_range(11, sps_pkg::CAPACITY);
        default: len = $urandom_range(1, 10);
      endcase
      if (len > target - pairs_sent) begin
        len = target - pairs_sent;
      end
      send_batch(len);
    end
    release_bus();
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_back_to_back_tail();
    idle_pct = 0;
    send_batch(6);
    send_batch(1);
    send_batch(12);
    release_bus();
  endtask

  // Result side: m_tready drops in random stall bursts, changed at the falling edge.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      m_tready   <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_tready   <= 1'b0;
      sink_stall <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expected pair.
  always @(posedge clk) begin
    sorted_item_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_q.size() == 0) begin
        $error("result item with no expected pair: key %0d", $signed(m_tdata[31:0]));
        fail_count++;
      end else begin
        exp_item = sorted_q.pop_front();
        if (m_tdata[31:0] !== exp_item.pair.key) begin
          $error("sorted_key: expected %0d, got %0d", $signed(exp_item.pair.key),
                 $signed(m_tdata[31:0]));
          fail_count++;
        end
        if (m_tdata[63:32] !== exp_item.pair.payload) begin
          $error("sorted_payload: expected %0d, got %0d", $signed(exp_item.pair.payload),
                 $signed(m_tdata[63:32]));
          fail_count++;
        end
        if (m_tlast !== exp_item.last) begin
          $error("final_result: expected %0b, got %0b", exp_item.last, m_tlast);
          fail_count++;
        end
        if (m_tuser !== exp_item.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_item.ovf, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_stable_pair_insertion_sorter_unit failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    m_tready      = 1'b0;
    sink_stall    = 0;
    fail_count    = 0;
    pairs_sent    = 0;
    cycle_count   = 0;
    batch_fill    = 0;
    batch_dropped = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_pair_batches();
    test_extremes_and_ties();
    test_full_store();
    test_random_batches();
    test_back_to_back_tail();

    // Drain, then give the block time to show any stray result.
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && sorted_q.size() == 0) begin
      $display("tb_stable_pair_insertion_sorter_unit passed");
    end else begin
      $display("tb_stable_pair_insertion_sorter_unit failed");
    end
    $finish;
  end

endmodule

// ===== stable_pair_insertion_sorter_unit.f =====
hdl/sps_pkg.sv
hdl/sps_store.sv
hdl/stable_pair_insertion_sorter_unit.sv
dv/tb_stable_pair_insertion_sorter_unit.sv
